>>> rtl/isbf_pkg.sv
`default_nettype none

package isbf_pkg;

  // table size and field widths
  localparam int TABLE_DEPTH = 64;
  localparam int ACTION_W    = 2;
  localparam int VERSION_W   = 4;
  localparam int ADDR_W      = 32;
  localparam int STATUS_W    = 2;

  // header version that takes part in the lookup
  localparam logic [VERSION_W-1:0] IPV4_VERSION = VERSION_W'(4);

  // command codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_CHECK = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_DEL   = 2'd2
  } action_t;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

`default_nettype wire

>>> rtl/isbf_ifs.sv
`default_nettype none

// command channel: check, add or delete an address
interface isbf_cmd_if import isbf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [VERSION_W-1:0] ip_version;
  logic [ADDR_W-1:0]    ip_addr;

  modport source (output valid, action, ip_version, ip_addr, input ready);
  modport sink   (input valid, action, ip_version, ip_addr, output ready);
endinterface

// result channel: drop decision and status
interface isbf_res_if import isbf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                drop;
  logic [STATUS_W-1:0] status;

  modport source (output valid, drop, status, input ready);
  modport sink   (input valid, drop, status, output ready);
endinterface

`default_nettype wire

>>> rtl/ipv4_source_blacklist_filter_core.sv
`default_nettype none

// IPv4 source blacklist filter. Holds up to TABLE_DEPTH (64) blocked addresses
// in registers, each with a valid bit that reset clears. Every command beat
// yields exactly one result beat: a check drops an IPv4 packet whose source
// matches a valid entry (other versions always pass), an add fills the lowest
// free entry or reports already present / table full, and a delete clears the
// matching entry or reports not found. The block takes one command per cycle:
// a command register feeds a parallel compare of all entries and the free-entry
// pick, the table is updated and the result registered on the same edge, so the
// next command already sees the new table. The result register stalls the
// command side only while it holds a beat that is not taken.
module ipv4_source_blacklist_filter_core import isbf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  isbf_cmd_if.sink    cmd,
  isbf_res_if.source  res
);

  // command register
  logic                 s1_valid;
  action_t              s1_action;
  logic [VERSION_W-1:0] s1_version;
  logic [ADDR_W-1:0]    s1_addr;

  // address table
  logic [ADDR_W-1:0]      entry_addr [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [TABLE_DEPTH-1:0] entry_valid_next;

  // result register
  logic    out_valid;
  logic    out_drop;
  status_t out_status;

  logic                   advance;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] free_vec;
  logic [TABLE_DEPTH-1:0] free_pick;
  logic [TABLE_DEPTH-1:0] add_vec;
  logic                   hit;
  logic                   full;
  logic                   drop_next;
  status_t                status_next;

  // handshake
  assign advance   = s1_valid && (!out_valid || res.ready);
  assign cmd.ready = !s1_valid || advance;

  // parallel compare against all valid entries
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_vec[i] = entry_valid[i] && (entry_addr[i] == s1_addr);
    end
  end

  // lowest free entry as a one-hot vector
  assign free_vec  = ~entry_valid;
  assign free_pick = free_vec & (~free_vec + TABLE_DEPTH'(1));
  assign hit       = |hit_vec;
  assign full      = &entry_valid;

  // command decode
  always_comb begin
    drop_next        = 1'b0;
    status_next      = ST_DONE;
    entry_valid_next = entry_valid;
    add_vec          = '0;
    case (s1_action)
      ACT_CHECK: begin
        drop_next = (s1_version == IPV4_VERSION) && hit;
      end
      ACT_ADD: begin
        if (hit) begin
          status_next = ST_PRESENT;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          add_vec          = free_pick;
          entry_valid_next = entry_valid | free_pick;
        end
      end
      ACT_DEL: begin
        if (!hit) begin
          status_next = ST_NOT_FOUND;
        end else begin
          entry_valid_next = entry_valid & ~hit_vec;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // command register load
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_action  <= action_t'(cmd.action);
      s1_version <= cmd.ip_version;
      s1_addr    <= cmd.ip_addr;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (advance) begin
      entry_valid <= entry_valid_next;
    end
  end

  // address storage, written only by a successful add
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (advance && add_vec[i]) begin
        entry_addr[i] <= s1_addr;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drop   <= drop_next;
      out_status <= status_next;
    end
  end

  assign res.valid  = out_valid;
  assign res.drop   = out_drop;
  assign res.status = out_status;

  // a command leaving the command register always lands in the result register
  assert property (@(posedge clk) disable iff (rst) advance |=> out_valid)
    else $error("result beat lost");

  // a dropped packet never carries a non-done status
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_drop |-> out_status == ST_DONE)
    else $error("drop with non-done status");

  // a successful add grows the table by exactly one entry
  assert property (@(posedge clk) disable iff (rst)
    advance && s1_action == ACT_ADD && status_next == ST_DONE |=>
    $countones(entry_valid) == $past($countones(entry_valid)) + 1)
    else $error("add did not fill exactly one entry");

  // the command side stalls only behind a held result
  assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> s1_valid && out_valid && !res.ready)
    else $error("command side stalled without cause");

endmodule

`default_nettype wire

>>> tb/sv/ipv4_source_blacklist_filter_core_tb.sv
`timescale 1ns / 100ps

module ipv4_source_blacklist_filter_core_tb;
  import isbf_pkg::*;

  typedef struct packed {
    action_t              action;
    logic [VERSION_W-1:0] ip_version;
    logic [ADDR_W-1:0]    ip_addr;
  } cmd_beat_t;

  typedef struct packed {
    logic    drop;
    status_t status;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;

  isbf_cmd_if cmd_bus ();
  isbf_res_if res_bus ();

  ipv4_source_blacklist_filter_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  // pending commands, expected verdicts, shadow blacklist
  cmd_beat_t         cmd_q[$];
  verdict_t          verdict_q[$];
  logic [ADDR_W-1:0] blk_addr[TABLE_DEPTH];
  bit                blk_used[TABLE_DEPTH];
  logic [ADDR_W-1:0] addr_pool[96];
  int                cmd_total = 0;
  int                cmd_sent = 0;
  int                res_seen = 0;
  int                fail_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the blacklist table: decide one command and update the table
  function automatic verdict_t blacklist_verdict(cmd_beat_t c);
    verdict_t v;
    int       hit;
    int       free_idx;
    v.drop   = 1'b0;
    v.status = ST_DONE;
    hit      = -1;
    free_idx = -1;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (blk_used[i] && blk_addr[i] == c.ip_addr) hit = i;
      if (!blk_used[i]) free_idx = i;
    end
    case (c.action)
      ACT_CHECK: v.drop = (c.ip_version == IPV4_VERSION) && (hit >= 0);
      ACT_ADD: begin
        if (hit >= 0) begin
          v.status = ST_PRESENT;
        end else if (free_idx < 0) begin
          v.status = ST_FULL;
        end else begin
          blk_addr[free_idx] = c.ip_addr;
          blk_used[free_idx] = 1'b1;
        end
      end
      ACT_DEL: begin
        if (hit < 0) v.status = ST_NOT_FOUND;
        else blk_used[hit] = 1'b0;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic push_cmd(action_t act, logic [VERSION_W-1:0] ver, logic [ADDR_W-1:0] addr);
    cmd_beat_t c;
    c.action     = act;
    c.ip_version = ver;
    c.ip_addr    = addr;
    cmd_q.push_back(c);
    cmd_total++;
  endtask

  // random command mix; add and delete weights steer the table toward full or empty
  task automatic push_random(int add_pct, int del_pct, int count);
    int                   r;
    logic [VERSION_W-1:0] ver;
    logic [ADDR_W-1:0]    addr;
    for (int n = 0; n < count; n++) begin
      r    = $urandom_range(0, 99);
      ver  = ($urandom_range(0, 99) < 70) ? IPV4_VERSION : VERSION_W'($urandom_range(0, 15));
      addr = addr_pool[$urandom_range(0, 95)];
      if (r < add_pct) begin
        push_cmd(ACT_ADD, ver, addr);
      end else if (r < add_pct + del_pct) begin
        if ($urandom_range(0, 99) < 15) addr = $urandom;
        push_cmd(ACT_DEL, ver, addr);
      end else begin
        if ($urandom_range(0, 99) < 20) addr = $urandom;
        push_cmd(ACT_CHECK, ver, addr);
      end
    end
  endtask

  // command driver: hold a beat until taken, idle at random outside the burst window
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else if (!cmd_bus.valid || cmd_bus.ready) begin
      if (cmd_bus.valid) begin
        verdict_q.push_back(blacklist_verdict(cmd_q.pop_front()));
        cmd_sent++;
      end
      if (cmd_q.size() > 0 &&
          ((cmd_sent >= 250 && cmd_sent < 400) || $urandom_range(0, 99) >= 30)) begin
        cmd_bus.valid      <= 1'b1;
        cmd_bus.action     <= cmd_q[0].action;
        cmd_bus.ip_version <= cmd_q[0].ip_version;
        cmd_bus.ip_addr    <= cmd_q[0].ip_addr;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // result monitor: compare each beat with the oldest expected verdict
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        res_seen++;
        if (verdict_q.size() == 0) begin
          $error("result beat with no command pending: drop %0d status %0d",
                 res_bus.drop, res_bus.status);
          fail_cnt++;
        end else begin
          verdict_t v;
          v = verdict_q.pop_front();
          if (res_bus.drop !== v.drop) begin
            $error("drop: expected %0d, actual %0d", v.drop, res_bus.drop);
            fail_cnt++;
          end
          if (res_bus.status !== v.status) begin
            $error("status: expected %0d, actual %0d", v.status, res_bus.status);
            fail_cnt++;
          end
        end
      end
      res_bus.ready <= (res_seen >= 250 && res_seen < 400) || ($urandom_range(0, 99) >= 30);
    end
  end

  // stimulus, reset and end of run
  initial begin
    rst                = 1'b1;
    cmd_bus.valid      = 1'b0;
    cmd_bus.action     = ACT_CHECK;
    cmd_bus.ip_version = '0;
    cmd_bus.ip_addr    = '0;
    res_bus.ready      = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      blk_used[i] = 1'b0;
      blk_addr[i] = '0;
    end

    // address pool with the extremes; repeats make hits, duplicates and deletes likely
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = 32'hC0A8_0001;
    for (int i = 3; i < 96; i++) addr_pool[i] = $urandom;

    // directed: empty lookup, add, duplicate, version gating, delete, slot reuse
    push_cmd(ACT_CHECK, IPV4_VERSION, 32'h0000_0000);
    push_cmd(ACT_ADD,   IPV4_VERSION, 32'h0000_0000);
    push_cmd(ACT_ADD,   4'd15,        32'hFFFF_FFFF);
    push_cmd(ACT_ADD,   IPV4_VERSION, 32'h0000_0000);
    push_cmd(ACT_CHECK, IPV4_VERSION, 32'h0000_0000);
    push_cmd(ACT_CHECK, IPV4_VERSION, 32'hFFFF_FFFF);
    push_cmd(ACT_CHECK, 4'd6,         32'h0000_0000);
    push_cmd(ACT_CHECK, 4'd15,        32'hFFFF_FFFF);
    push_cmd(ACT_CHECK, 4'd0,         32'h0000_0000);
    push_cmd(ACT_CHECK, IPV4_VERSION, 32'hFFFF_FFFE);
    push_cmd(ACT_DEL,   IPV4_VERSION, 32'h0000_0000);
    push_cmd(ACT_DEL,   4'd0,         32'h0000_0000);
    push_cmd(ACT_CHECK, IPV4_VERSION, 32'h0000_0000);
    push_cmd(ACT_ADD,   IPV4_VERSION, 32'hC0A8_0001);
    push_cmd(ACT_CHECK, IPV4_VERSION, 32'hC0A8_0001);
    push_cmd(ACT_DEL,   IPV4_VERSION, 32'hFFFF_FFFF);
    push_cmd(ACT_DEL,   IPV4_VERSION, 32'hC0A8_0001);
    push_cmd(ACT_DEL,   IPV4_VERSION, 32'h1234_5678);

    // random: fill to full, mixed traffic, drain, refill
    push_random(65, 5, 175);
    push_random(25, 25, 175);
    push_random(10, 60, 175);
    push_random(70, 5, 175);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (cmd_sent < cmd_total || verdict_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (verdict_q.size() > 0) begin
      $error("%0d expected results never arrived", verdict_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
